/* rtl/core/rtpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rtpd_pkg;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  localparam int unsigned RES_MAX = 4;

  // Version strings, byte 0 first.
  localparam logic [0:7][7:0] VER_A = "HTTP/1.1";
  localparam logic [0:7][7:0] VER_B = "HTTP/1.0";

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_TARGET,
    PH_GAP,
    PH_TOKEN
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       is_end;
    logic       version_seen;
    logic       status;
  } out_item_t;

  // Target decode state: pending count, byte after a held '%', held slash.
  typedef struct packed {
    logic [1:0] pcnt;
    logic [7:0] pbyte;
    logic       held;
    logic       emitted;
  } tgt_t;

  typedef struct packed {
    logic [3:0] idx;
    logic [1:0] match;
  } ver_t;

  typedef struct packed {
    phase_t phase;
    tgt_t   tgt;
    ver_t   ver;
    logic   tseen;
  } dec_state_t;

  typedef struct packed {
    logic [2:0]               cnt;
    out_item_t [RES_MAX-1:0]  item;
  } batch_t;

  typedef struct packed {
    tgt_t   tgt;
    batch_t res;
  } work_t;

  localparam dec_state_t DEC_RESET = '{
    phase: PH_LEAD,
    tgt:   '0,
    ver:   '{idx: 4'd0, match: 2'b11},
    tseen: 1'b0
  };

  function automatic work_t push_byte(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    if (r.res.cnt < 3'(RES_MAX)) begin
      r.res.item[r.res.cnt[1:0]] = '{out_byte: b, is_data: 1'b1, is_end: 1'b0,
                                     version_seen: 1'b0, status: 1'b0};
      r.res.cnt = 3'(r.res.cnt + 3'd1);
    end
    r.tgt.emitted = 1'b1;
    return r;
  endfunction

  // Hex digit value, upper case only; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic logic code_ok(logic [7:0] v);
    logic ok;
    case (v) inside
      8'h20, 8'h21, [8'h23:8'h29], [8'h2B:8'h2E], 8'h3B, 8'h3D, 8'h40,
      8'h5B, [8'h5D:8'h60], 8'h7B, 8'h7D, 8'h7E: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // One byte into the target with nothing pending.
  function automatic work_t feed_idle(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (r.tgt.held) begin
      r = push_byte(r, CH_SLASH);
      r.tgt.held = 1'b0;
    end
    if (c == CH_SLASH) begin
      r.tgt.held = 1'b1;
    end else if (c == CH_PERCENT) begin
      r.tgt.pcnt = 2'd1;
    end else begin
      r = push_byte(r, c);
    end
    return r;
  endfunction

  function automatic work_t feed(work_t w, logic [7:0] c);
    work_t      r;
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] b;
    r  = w;
    hi = hex_val(w.tgt.pbyte);
    lo = hex_val(c);
    b  = w.tgt.pbyte;
    case (w.tgt.pcnt)
      2'd0: r = feed_idle(r, c);
      2'd1: begin
        r.tgt.pbyte = c;
        r.tgt.pcnt  = 2'd2;
      end
      default: begin
        r.tgt.pcnt = 2'd0;
        if (hi[4] && lo[4] && code_ok({hi[3:0], lo[3:0]})) begin
          r = push_byte(r, {hi[3:0], lo[3:0]});
        end else begin
          // Pass the '%' through and look at both bytes again.
          r = push_byte(r, CH_PERCENT);
          r = feed_idle(r, b);
          if (r.tgt.pcnt == 2'd1) begin
            r.tgt.pbyte = c;
            r.tgt.pcnt  = 2'd2;
          end else begin
            r = feed_idle(r, c);
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic work_t finish(work_t w);
    work_t r;
    r = w;
    if (r.tgt.pcnt == 2'd2) begin
      r.tgt.pcnt = 2'd0;
      r = push_byte(r, CH_PERCENT);
      r = feed_idle(r, w.tgt.pbyte);
    end
    if (r.tgt.pcnt == 2'd1) begin
      r.tgt.pcnt = 2'd0;
      r = push_byte(r, CH_PERCENT);
    end
    if (r.tgt.held) begin
      if (!r.tgt.emitted) begin
        r = push_byte(r, CH_SLASH);
      end
      r.tgt.held = 1'b0;
    end
    return r;
  endfunction

  function automatic ver_t token_byte(ver_t v, logic [7:0] c);
    ver_t r;
    r = v;
    if (!v.idx[3]) begin
      if (c == CH_SPACE) begin
        r.match = 2'b00;
        r.idx   = 4'd8;
      end else begin
        if (c != VER_A[v.idx[2:0]]) r.match[0] = 1'b0;
        if (c != VER_B[v.idx[2:0]]) r.match[1] = 1'b0;
        r.idx = 4'(v.idx + 4'd1);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rtpd_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtpd_step import rtpd_pkg::*; (
  input  dec_state_t st,
  input  in_item_t   item,
  output dec_state_t st_nxt,
  output batch_t     batch
);

  work_t      w;
  dec_state_t nxt;
  logic [7:0] c;
  logic       bad;

  always_comb begin
    c     = item.in_byte;
    nxt   = st;
    w.tgt = st.tgt;
    w.res = '0;
    bad   = 1'b0;

    case (st.phase)
      PH_LEAD: begin
        if (c == CH_SPACE) begin
          w = push_byte(w, c);
        end else begin
          nxt.phase = PH_TARGET;
          w = feed(w, c);
        end
      end
      PH_TARGET: begin
        if (c == CH_SPACE) begin
          w = finish(w);
          nxt.phase = PH_GAP;
        end else begin
          w = feed(w, c);
        end
      end
      PH_GAP: begin
        if (c != CH_SPACE) begin
          nxt.tseen = 1'b1;
          nxt.phase = PH_TOKEN;
          nxt.ver   = token_byte(st.ver, c);
        end
      end
      default: nxt.ver = token_byte(st.ver, c);
    endcase

    if (item.is_last) begin
      if (nxt.phase inside {PH_LEAD, PH_TARGET}) begin
        w = finish(w);
      end
      bad = nxt.tseen && (!nxt.ver.idx[3] || nxt.ver.match == 2'b00);
      if (w.res.cnt < 3'(RES_MAX)) begin
        w.res.item[w.res.cnt[1:0]] = '{out_byte: 8'h00, is_data: 1'b0, is_end: 1'b1,
                                       version_seen: nxt.tseen, status: bad};
        w.res.cnt = 3'(w.res.cnt + 3'd1);
      end
    end

    nxt.tgt = w.tgt;
    st_nxt  = item.is_last ? DEC_RESET : nxt;
    batch   = w.res;
  end

endmodule

`default_nettype wire

/* rtl/core/rtpd_res_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtpd_res_buf import rtpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  batch_t    batch,
  output logic      load_ok,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [2:0]              cnt_r;
  logic [2:0]              cnt_nxt;
  out_item_t [RES_MAX-1:0] items_r;
  out_item_t [RES_MAX-1:0] items_nxt;
  logic                    fire;

  assign fire      = (cnt_r != 3'd0) && !out_stall;
  assign load_ok   = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && !out_stall);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = items_r[0];

  always_comb begin
    cnt_nxt   = cnt_r;
    items_nxt = items_r;
    if (load) begin
      cnt_nxt   = batch.cnt;
      items_nxt = batch.item;
    end else if (fire) begin
      // advance the queue by one entry
      cnt_nxt = 3'(cnt_r - 3'd1);
      for (int i = 0; i < RES_MAX - 1; i++) begin
        items_nxt[i] = items_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    items_r <= items_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/request_target_percent_decoder.sv */
// Request-target percent decoder.
// Input channel (in_valid / in_stall / in_data): one byte of an HTTP request
// line per transaction, starting after the method keyword, CR removed, the
// final byte flagged by is_last. Output channel (out_valid / out_stall /
// out_data): decoded target bytes (is_data = 1), then one summary transaction
// (is_end = 1) per line carrying version_seen and status.
// An accepted byte waits in the input register, is decoded combinationally,
// and its results load into the registered result queue once it can take them.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_stall is low. A byte that yields k results (up to four: a rejected
// escape plus the end of line) holds the queue until all k have left. The
// queue drains one result per cycle unless stalled; it alone limits the rate.
// Reset (rst_n low, synchronous) empties the input register and the result
// queue and returns the decoder to the start-of-line state. Each summary
// also returns the decoder to that state.
// When the receiver stalls, the front result holds; the input register keeps
// one byte and in_stall rises once that byte cannot enter the queue.
`timescale 1ns / 1ps
`default_nettype none

module request_target_percent_decoder import rtpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Input register
  logic       iv_r;
  logic       iv_nxt;
  in_item_t   item_r;

  // Decoder state
  dec_state_t st_r;
  dec_state_t st_nxt;

  batch_t     batch;
  logic       load_ok;
  logic       advance;

  // Move the held byte into the result queue once the queue frees up.
  assign advance  = iv_r && load_ok;
  assign in_stall = iv_r && !load_ok;
  assign iv_nxt   = in_stall ? iv_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
    end
  end

  // Capture a new transaction whenever the register is not held.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_data;
    end
  end

  // Decode one byte: all of its results in one pass.
  rtpd_step u_step (
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .batch  (batch)
  );

  // Commit decoder state only when the byte's results are taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DEC_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  rtpd_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .batch     (batch),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rtpd_pkg::*;

  // Escape codes that decode; each turns into the byte of its hex value.
  localparam logic [23:0][7:0] ESC_CODES = {
    8'h20, 8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h2C, 8'h2D,
    8'h2E, 8'h3B, 8'h3D, 8'h40, 8'h5B, 8'h5D, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7E
  };

  // One directed transaction. Rows with typed set carry their expectation:
  // an optional data byte, then the line summary.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic       has_byte;
    logic [7:0] exp_byte;
    logic       exp_seen;
    logic       exp_status;
  } row_t;

  localparam int NUM_ROWS = 26;
  localparam row_t [0:NUM_ROWS-1] DIR_ROWS = '{
    // lone slash is the whole target and survives
    '{8'h2F, 1'b1, 1'b1, 1'b1, 8'h2F, 1'b0, 1'b0},
    // smallest and largest byte values
    '{8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0},
    // line made of spaces only
    '{8'h20, 1'b1, 1'b1, 1'b1, 8'h20, 1'b0, 1'b0},
    // "%2B/ X": decoded plus, trailing slash dropped, short bad token
    '{"%",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"2",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"B",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"/",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h20, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"X",   1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1},
    // tab, CR, LF as plain bytes; escape cut off by the end of the line
    '{8'h09, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h0D, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h0A, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"%",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"4",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // "a HTTP/1.0Z": good version, byte past the eighth ignored
    '{"a",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h20, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"H",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"T",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"T",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"P",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"/",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"1",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{".",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"0",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"Z",   1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Idle chances in percent, and the one long receiver hold-off.
  int   send_idle_pct = 12;
  int   recv_idle_pct = 51;
  logic hold_go = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  // Decoder state mirrored on the testbench side.
  phase_t     line_phase;
  logic [1:0] esc_cnt;
  logic [7:0] esc_byte;
  logic       slash_held;
  logic       target_started;
  logic [3:0] tok_idx;
  logic [1:0] tok_match;
  logic       tok_seen;
  int         step_count;
  bit         record_step;

  out_item_t  decoded_q [$];
  logic [7:0] line_bytes [$];

  int mismatches = 0;
  int results_checked = 0;
  int summaries_checked = 0;
  int lines_sent = 0;
  int bytes_sent = 0;
  int random_bytes = 0;

  request_target_percent_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Return the decoder to its start-of-line state.
  function automatic void clear_line();
    line_phase     = PH_LEAD;
    esc_cnt        = 2'd0;
    esc_byte       = 8'h00;
    slash_held     = 1'b0;
    target_started = 1'b0;
    tok_idx        = 4'd0;
    tok_match      = 2'b11;
    tok_seen       = 1'b0;
  endfunction

  // Queue one result; a single byte never yields more than RES_MAX of them.
  function automatic void post_result(logic [7:0] b, logic dat, logic fin, logic seen,
                                      logic st);
    out_item_t r;
    if (step_count >= RES_MAX) return;
    step_count++;
    r = '{out_byte: b, is_data: dat, is_end: fin, version_seen: seen, status: st};
    if (record_step) decoded_q.push_back(r);
  endfunction

  function automatic void emit_target(logic [7:0] b);
    post_result(b, 1'b1, 1'b0, 1'b0, 1'b0);
    target_started = 1'b1;
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // Value of a listed escape, or -1 when the pair does not form one.
  function automatic int escape_value(logic [7:0] hi, logic [7:0] lo);
    int h;
    int l;
    int v;
    h = hex_nibble(hi);
    l = hex_nibble(lo);
    if (h < 0 || l < 0) return -1;
    v = h * 16 + l;
    for (int i = 0; i < 24; i++) begin
      if (ESC_CODES[i] == v[7:0]) return v;
    end
    return -1;
  endfunction

  function automatic void feed_target(logic [7:0] c);
    logic [7:0] second;
    int         v;
    if (esc_cnt == 2'd0) begin
      // A held slash was not the trailing one once another byte shows up.
      if (slash_held) begin
        emit_target(CH_SLASH);
        slash_held = 1'b0;
      end
      if (c == CH_SLASH) begin
        slash_held = 1'b1;
      end else if (c == CH_PERCENT) begin
        esc_cnt = 2'd1;
      end else begin
        emit_target(c);
      end
    end else if (esc_cnt == 2'd1) begin
      esc_byte = c;
      esc_cnt  = 2'd2;
    end else begin
      v       = escape_value(esc_byte, c);
      esc_cnt = 2'd0;
      if (v >= 0) begin
        emit_target(v[7:0]);
      end else begin
        // Pass the '%' through and rescan both bytes behind it.
        second = esc_byte;
        emit_target(CH_PERCENT);
        feed_target(second);
        feed_target(c);
      end
    end
  endfunction

  // Flush whatever the target still holds when it ends.
  function automatic void close_target();
    if (esc_cnt == 2'd2) begin
      esc_cnt = 2'd0;
      emit_target(CH_PERCENT);
      feed_target(esc_byte);
    end
    if (esc_cnt == 2'd1) begin
      esc_cnt = 2'd0;
      emit_target(CH_PERCENT);
    end
    if (slash_held) begin
      if (!target_started) emit_target(CH_SLASH);
      slash_held = 1'b0;
    end
  endfunction

  function automatic void check_version(logic [7:0] c);
    if (tok_idx[3]) return;
    if (c == CH_SPACE) begin
      tok_match = 2'b00;
      tok_idx   = 4'd8;
      return;
    end
    if (c != VER_A[tok_idx[2:0]]) tok_match[0] = 1'b0;
    if (c != VER_B[tok_idx[2:0]]) tok_match[1] = 1'b0;
    tok_idx = tok_idx + 4'd1;
  endfunction

  // Advance the mirrored decoder by one byte; with record set, queue the results.
  function automatic void predict_byte(in_item_t it, bit record);
    logic st;
    step_count  = 0;
    record_step = record;
    case (line_phase)
      PH_LEAD: begin
        if (it.in_byte == CH_SPACE) begin
          emit_target(CH_SPACE);
        end else begin
          line_phase = PH_TARGET;
          feed_target(it.in_byte);
        end
      end
      PH_TARGET: begin
        if (it.in_byte == CH_SPACE) begin
          close_target();
          line_phase = PH_GAP;
        end else begin
          feed_target(it.in_byte);
        end
      end
      PH_GAP: begin
        if (it.in_byte != CH_SPACE) begin
          tok_seen   = 1'b1;
          line_phase = PH_TOKEN;
          check_version(it.in_byte);
        end
      end
      default: check_version(it.in_byte);
    endcase
    if (it.is_last) begin
      if (line_phase == PH_LEAD || line_phase == PH_TARGET) close_target();
      st = tok_seen && (!tok_idx[3] || tok_match == 2'b00);
      post_result(8'h00, 1'b0, 1'b1, tok_seen, st);
      clear_line();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random line builder
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? 8'("0" + n) : 8'("A" + n - 10);
  endfunction

  // Mostly upper-case hex digits, sometimes a byte that spoils the escape.
  function automatic logic [7:0] near_hex();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range("a", "f"));
      1: return CH_PERCENT;
      2: return CH_SLASH;
      3: return "G";
      default: return hex_char(4'($urandom_range(0, 15)));
    endcase
  endfunction

  task automatic add_target_piece();
    logic [7:0] code;
    case ($urandom_range(0, 7))
      0, 1: line_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
      2: line_bytes.push_back(CH_SLASH);
      3, 4: begin
        code = ESC_CODES[$urandom_range(0, 23)];
        line_bytes.push_back(CH_PERCENT);
        line_bytes.push_back(hex_char(code[7:4]));
        line_bytes.push_back(hex_char(code[3:0]));
      end
      5: begin
        line_bytes.push_back(CH_PERCENT);
        line_bytes.push_back(near_hex());
        line_bytes.push_back(near_hex());
      end
      6: line_bytes.push_back(CH_PERCENT);
      default: line_bytes.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Version token: exact, with one byte spoiled, cut short or run long.
  task automatic add_token();
    logic [0:7][7:0] ver;
    int              n;
    int              kind;
    ver  = ($urandom_range(0, 1) != 0) ? VER_A : VER_B;
    n    = 8;
    kind = $urandom_range(0, 5);
    if (kind == 0) ver[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
    if (kind == 1) n = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) line_bytes.push_back(ver[i]);
    if (kind == 2) begin
      repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Build one request line: mostly well formed, one in ten pure noise.
  task automatic make_line();
    int kind;
    line_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 10)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) line_bytes.push_back(CH_SPACE);
      repeat ($urandom_range(1, 5)) add_target_piece();
      if (kind >= 3) begin
        repeat ($urandom_range(1, 2)) line_bytes.push_back(CH_SPACE);
        add_token();
        if ($urandom_range(0, 3) == 0) begin
          line_bytes.push_back(CH_SPACE);
          repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end else if (kind == 2) begin
        // target followed by spaces only
        repeat ($urandom_range(1, 2)) line_bytes.push_back(CH_SPACE);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction, idling first at random; return once it is taken.
  task automatic drive_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_line();
    in_item_t it;
    for (int i = 0; i < line_bytes.size(); i++) begin
      it.in_byte = line_bytes[i];
      it.is_last = (i == line_bytes.size() - 1);
      predict_byte(it, 1'b1);
      drive_item(it);
      random_bytes++;
    end
    lines_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: check each result transaction, then choose the next stall
  // ---------------------------------------------------------------------------

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t: unexpected result byte=%02h data=%b end=%b seen=%b status=%b",
               $time, got.out_byte, got.is_data, got.is_end, got.version_seen, got.status);
      mismatches++;
      return;
    end
    want = decoded_q.pop_front();
    results_checked++;
    if (want.is_end) summaries_checked++;
    if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
        got.is_end !== want.is_end || got.version_seen !== want.version_seen ||
        got.status !== want.status) begin
      $display("%0t: expected byte=%02h data=%b end=%b seen=%b status=%b,",
               $time, want.out_byte, want.is_data, want.is_end, want.version_seen,
               want.status,
               " actual byte=%02h data=%b end=%b seen=%b status=%b",
               got.out_byte, got.is_data, got.is_end, got.version_seen, got.status);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    // Start the long hold-off once, when asked, and count it down here.
    if (hold_go && !hold_done) begin
      hold_left = 80;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    in_item_t  it;
    out_item_t want;
    clear_line();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: typed rows queue their own expectation and only advance
    // the mirrored state; the rest are predicted.
    for (int r = 0; r < NUM_ROWS; r++) begin
      it = '{in_byte: DIR_ROWS[r].ch, is_last: DIR_ROWS[r].last};
      predict_byte(it, !DIR_ROWS[r].typed);
      if (DIR_ROWS[r].typed) begin
        if (DIR_ROWS[r].has_byte) begin
          want = '{out_byte: DIR_ROWS[r].exp_byte, is_data: 1'b1, is_end: 1'b0,
                   version_seen: 1'b0, status: 1'b0};
          decoded_q.push_back(want);
        end
        want = '{out_byte: 8'h00, is_data: 1'b0, is_end: 1'b1,
                 version_seen: DIR_ROWS[r].exp_seen, status: DIR_ROWS[r].exp_status};
        decoded_q.push_back(want);
      end
      drive_item(it);
    end

    // Random lines in three stretches: light sender idling with heavy
    // receiver stalls, the reverse, then none with one long hold-off.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 51;
        recv_idle_pct <= 12;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_go <= 1'b1;
      end
      while (random_bytes < (ph + 1) * 56) begin
        make_line();
        send_line();
      end
    end
    in_valid <= 1'b0;

    // Drain, then keep clocking so that any extra result would show.
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d random lines and %0d bytes in all;", lines_sent, bytes_sent,
             " checked %0d results, %0d line summaries", results_checked,
             summaries_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
